FILE: hdl/linear_interpolation_upsampler_assert.svh
// ---------------------------------------------------------------------------
// Linear interpolation upsampler assertion macros
// Shorthand for the concurrent checks, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERPOLATION_UPSAMPLER_ASSERT_SVH
`define LINEAR_INTERPOLATION_UPSAMPLER_ASSERT_SVH

// same-cycle implication
`define LIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lip assertion failed");

// next-cycle implication
`define LIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lip assertion failed");

`endif

FILE: hdl/lip_pkg.sv
// ---------------------------------------------------------------------------
// Linear interpolation upsampler package
// Widths, fixed-point constants and divider handshake types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lip_pkg;

  localparam int FracBits  = 8;
  localparam int SampleW   = 16;
  localparam int DiffW     = SampleW + 1;
  localparam int MagW      = SampleW + FracBits;
  localparam int ScaledW   = MagW + 1;
  localparam int PointW    = 24;
  localparam int FactorW   = 7;
  localparam int FactorMax = 64;
  localparam int FactorRst = 4;
  localparam int RemW      = FactorW - 1;
  localparam int CntW      = RemW;
  localparam int DivCntW   = $clog2(MagW);

  typedef struct packed {
    logic start;
    logic neg;
  } lip_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lip_div_sts_t;

endpackage

FILE: hdl/linear_interpolation_upsampler.sv
// Each accepted sample with a stored predecessor costs one divider pass (one quotient
// bit per cycle in the restoring divider), a load of the step and then the emission of
// factor points, each held while the output stalls. The input therefore stays stalled
// from such a sample until its last point is registered, and the next sample is taken
// once the stall drops. A first sample of a track is taken without a divider pass and
// without a stall. Points come out of a register, so the last point may still wait on
// the output while the next sample is accepted. The factor register is read when a
// sample is accepted; zero acts as one and values above 64 act as 64.
// ---------------------------------------------------------------------------
// Linear interpolation upsampler
// Stores the previous sample and emits factor interpolated fixed-point points
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_interpolation_upsampler import lip_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [FactorW-1:0]        upsample_factor_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      end_of_track_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [PointW-1:0]  point_o,
  output logic                      last_of_run_o
);

`include "linear_interpolation_upsampler_assert.svh"

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  state_e                     state_q;
  logic [FactorW-1:0]         factor_q;
  logic [FactorW-1:0]         f_q;
  logic signed [SampleW-1:0]  prev_q;
  logic                       have_q;
  logic signed [PointW-1:0]   acc_q;
  logic signed [PointW-1:0]   step_q;
  logic [CntW-1:0]            cnt_q;
  logic                       out_valid_q;
  logic signed [PointW-1:0]   point_q;
  logic                       last_q;

  logic [FactorW-1:0]         eff_factor;
  logic signed [DiffW-1:0]    diff;
  logic signed [ScaledW-1:0]  scaled;
  logic [MagW-1:0]            mag;
  logic signed [PointW-1:0]   base;
  logic                       is_last;
  logic                       slot_free;
  lip_div_req_t               div_req;
  lip_div_sts_t               div_sts;
  logic signed [ScaledW-1:0]  div_quot;

  // clamp factor to 1..64
  always_comb begin
    if (factor_q == '0) begin
      eff_factor = FactorW'(1);
    end else if (factor_q > FactorW'(FactorMax)) begin
      eff_factor = FactorW'(FactorMax);
    end else begin
      eff_factor = factor_q;
    end
  end

  assign diff   = DiffW'(sample_i) - DiffW'(prev_q);
  assign scaled = ScaledW'(diff) <<< FracBits;
  assign mag    = scaled[ScaledW-1] ? MagW'(-scaled) : MagW'(scaled);
  assign base   = PointW'(ScaledW'(prev_q) <<< FracBits);

  assign div_req.start = (state_q == StIdle) && in_valid_i && have_q;
  assign div_req.neg   = scaled[ScaledW-1];

  lip_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .mag_i     (mag),
    .divisor_i (eff_factor),
    .sts_o     (div_sts),
    .quot_o    (div_quot)
  );

  assign is_last   = {1'b0, cnt_q} == (f_q - 1'b1);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      factor_q    <= FactorW'(FactorRst);
      f_q         <= FactorW'(1);
      prev_q      <= '0;
      have_q      <= 1'b0;
      acc_q       <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      point_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        factor_q <= upsample_factor_i;
      end
      if (!out_stall_i && state_q != StEmit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            prev_q <= end_of_track_i ? '0 : sample_i;
            have_q <= !end_of_track_i;
            if (have_q) begin
              f_q     <= eff_factor;
              acc_q   <= base;
              cnt_q   <= '0;
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (div_sts.done) begin
            step_q  <= PointW'(div_quot);
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            point_q     <= acc_q;
            last_q      <= is_last;
            acc_q       <= acc_q + step_q;
            cnt_q       <= cnt_q + 1'b1;
            if (is_last) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = state_q != StIdle;
  assign out_valid_o   = out_valid_q;
  assign point_o       = point_q;
  assign last_of_run_o = last_q;

  `LIP_ASSERT_NEXT(a_div_done_emit, div_sts.done, state_q == StEmit)
  `LIP_ASSERT_SAME(a_div_runs, state_q == StDiv, div_sts.busy || div_sts.done)
  `LIP_ASSERT_SAME(a_cnt_range, state_q == StEmit, {1'b0, cnt_q} < f_q)
  `LIP_ASSERT_SAME(a_factor_range, state_q != StIdle,
                   f_q != '0 && f_q <= FactorW'(FactorMax))

endmodule

FILE: hdl/lip_div.sv
// ---------------------------------------------------------------------------
// Linear interpolation upsampler step divider
// Restoring divider, one quotient bit per cycle, truncates toward zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lip_div import lip_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lip_div_req_t              req_i,
  input  logic [MagW-1:0]           mag_i,
  input  logic [FactorW-1:0]        divisor_i,
  output lip_div_sts_t              sts_o,
  output logic signed [ScaledW-1:0] quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               neg_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [MagW-1:0]    quo_q, quo_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [FactorW-1:0] div_q;
  logic [FactorW-1:0] trial;
  logic               ge;

  assign trial = {rem_q, quo_q[MagW-1]};
  assign ge    = trial >= div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = mag_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[MagW-2:0], ge};
      rem_d = ge ? RemW'(trial - div_q) : RemW'(trial);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(MagW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      neg_q <= req_i.neg;
      div_q <= divisor_i;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule
